FILE: rtl/core/s20_pkg.sv
// ----------------------------------------------------------------------------
// s20_pkg
// Shared types, constants and helpers for the Salsa20 stream cipher core.
// ----------------------------------------------------------------------------
package s20_pkg;

  localparam int unsigned RoundCountDef = 20;
  localparam int unsigned CfgIdxW       = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_01   = 3'd0,
    REG_KEY_23   = 3'd1,
    REG_KEY_45   = 3'd2,
    REG_KEY_67   = 3'd3,
    REG_NONCE    = 3'd4,
    REG_KEY_IS_256 = 3'd5
  } s20_reg_e;

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;
  localparam logic [31:0] TAU_1   = 32'h3120646e;
  localparam logic [31:0] TAU_2   = 32'h79622d36;

  typedef logic [15:0][31:0] s20_block_t;

  typedef struct packed {
    logic busy;
    logic done;
  } s20_status_t;

  // Rotate left by 7, 9, 13 or 18 for quarter-round steps 0 to 3.
  function automatic logic [31:0] rotl_step(input logic [31:0] v, input logic [1:0] step);
    logic [31:0] r;
    case (step)
      2'd0:    r = {v[24:0], v[31:25]};
      2'd1:    r = {v[22:0], v[31:23]};
      2'd2:    r = {v[18:0], v[31:19]};
      2'd3:    r = {v[13:0], v[31:14]};
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic s20_block_t init_block(
    input logic [63:0] key01,
    input logic [63:0] key23,
    input logic [63:0] key45,
    input logic [63:0] key67,
    input logic [63:0] nonce,
    input logic [63:0] ctr,
    input logic        key256
  );
    s20_block_t  b;
    logic [63:0] hi_lo;
    logic [63:0] hi_hi;
    hi_lo  = key256 ? key45 : key01;
    hi_hi  = key256 ? key67 : key23;
    b[0]   = SIGMA_0;
    b[1]   = key01[31:0];
    b[2]   = key01[63:32];
    b[3]   = key23[31:0];
    b[4]   = key23[63:32];
    b[5]   = key256 ? SIGMA_1 : TAU_1;
    b[6]   = nonce[31:0];
    b[7]   = nonce[63:32];
    b[8]   = ctr[31:0];
    b[9]   = ctr[63:32];
    b[10]  = key256 ? SIGMA_2 : TAU_2;
    b[11]  = hi_lo[31:0];
    b[12]  = hi_lo[63:32];
    b[13]  = hi_hi[31:0];
    b[14]  = hi_hi[63:32];
    b[15]  = SIGMA_3;
    return b;
  endfunction

endpackage

FILE: rtl/core/salsa20_stream_cipher.sv
// ----------------------------------------------------------------------------
// salsa20_stream_cipher
// Salsa20 byte-stream encryptor: each input beat's byte is XORed with the
// next keystream byte. A byte that does not start a keystream block passes
// through a pending register and then the output register. A byte at block
// position 0 first runs the block function on one shared 32-bit
// add-rotate-xor unit, one quarter-round step per cycle, then adds the input
// words back one word per cycle. Writing the nonce clears the block counter
// and restarts the block; a beat with tlast set ends the message and the
// next byte starts a fresh block. Configuration writes are taken every cycle
// and must be made while the block is idle.
// ----------------------------------------------------------------------------
module salsa20_stream_cipher import s20_pkg::*; #(
  parameter int unsigned ROUND_COUNT = RoundCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // [7:0] out_byte
  output logic               m_axis_tlast,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce_q, ctr_q;
  logic        key256_q;
  logic [5:0]  pos_q;
  logic        pend_q;
  logic [7:0]  pend_byte_q;
  logic        pend_last_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  logic        in_acc;
  logic        start;
  logic        emit;
  logic        cfg_acc;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;
  s20_block_t  init_blk;
  s20_status_t status;

  assign s_axis_tready = !pend_q;
  assign cfg_ready_o   = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign start         = in_acc && (pos_q == 6'd0);
  assign emit          = pend_q && !status.busy && (!out_valid_q || m_axis_tready);
  assign init_blk      = init_block(key01_q, key23_q, key45_q, key67_q,
                                    nonce_q, ctr_q, key256_q);
  assign ks_byte       = 8'(ks_word >> {pos_q[1:0], 3'b000});

  s20_core #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .init_i   (init_blk),
    .rd_idx_i (pos_q[5:2]),
    .rd_word_o(ks_word),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q     <= '0;
      key23_q     <= '0;
      key45_q     <= '0;
      key67_q     <= '0;
      nonce_q     <= '0;
      key256_q    <= 1'b1;
      ctr_q       <= '0;
      pos_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        pend_q <= 1'b1;
      end
      if (emit) begin
        pend_q      <= 1'b0;
        out_valid_q <= 1'b1;
        pos_q       <= pend_last_q ? 6'd0 : pos_q + 6'd1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (status.done) begin
        ctr_q <= ctr_q + 64'd1;
      end
      if (cfg_acc) begin
        case (s20_reg_e'(cfg_index_i))
          REG_KEY_01:     key01_q  <= cfg_data_i;
          REG_KEY_23:     key23_q  <= cfg_data_i;
          REG_KEY_45:     key45_q  <= cfg_data_i;
          REG_KEY_67:     key67_q  <= cfg_data_i;
          REG_NONCE: begin
            nonce_q <= cfg_data_i;
            ctr_q   <= '0;
            pos_q   <= '0;
          end
          REG_KEY_IS_256: key256_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_byte_q <= s_axis_tdata;
      pend_last_q <= s_axis_tlast;
    end
    if (emit) begin
      out_byte_q <= pend_byte_q ^ ks_byte;
      out_last_q <= pend_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  a_busy_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> pend_q)
    else $error("core running without a pending byte");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !status.busy)
    else $error("input beat taken while core busy");

  a_emit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (m_axis_tvalid && !pend_q))
    else $error("emitted byte did not reach the output register");

endmodule

FILE: rtl/core/s20_core.sv
// ----------------------------------------------------------------------------
// s20_core
// Block function: one add-rotate-xor unit steps the quarter rounds on column
// 0 (even rounds) or row 0 (odd rounds) of the state, re-aligned diagonally
// after each quarter round, then adds the input words back one word per cycle.
// ----------------------------------------------------------------------------
module s20_core import s20_pkg::*; #(
  parameter int unsigned ROUND_COUNT = RoundCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  s20_block_t  init_i,
  input  logic [3:0]  rd_idx_i,
  output logic [31:0] rd_word_o,
  output s20_status_t status_o
);

  localparam int unsigned RndW = $clog2(ROUND_COUNT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [3:0]      idx_q, idx_d;
  logic [RndW-1:0] round_q, round_d;
  s20_block_t      x_q, x_d;

  logic        row_sel;
  logic [31:0] quad [4];
  logic [31:0] nquad [4];
  logic [31:0] add_a, add_b, sum, mix;
  s20_block_t  xq, xs;

  always_comb begin
    row_sel = round_q[0];
    for (int k = 0; k < 4; k++) begin
      quad[k] = row_sel ? x_q[k] : x_q[4*k];
    end
    add_a = (state_q == ST_ADD) ? x_q[0] : quad[0];
    add_b = (state_q == ST_ADD) ? init_i[idx_q] : quad[3];
    sum   = add_a + add_b;
    mix   = quad[1] ^ rotl_step(sum, idx_q[1:0]);

    nquad[0] = mix;
    nquad[1] = quad[2];
    nquad[2] = quad[3];
    nquad[3] = quad[0];
    xq = x_q;
    for (int k = 0; k < 4; k++) begin
      if (row_sel) begin
        xq[k] = nquad[k];
      end else begin
        xq[4*k] = nquad[k];
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs[i] = xq[(((i >> 2) + 1) & 3) * 4 + ((i + 1) & 3)];
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    round_d = round_q;
    x_d     = x_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d     = init_i;
          state_d = ST_ROUND;
          idx_d   = '0;
          round_d = '0;
        end
      end
      ST_ROUND: begin
        x_d   = (idx_q[1:0] == 2'd3) ? xs : xq;
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'hF) begin
          if (round_q == RndW'(ROUND_COUNT - 1)) begin
            state_d = ST_ADD;
            round_d = '0;
          end else begin
            round_d = round_q + RndW'(1);
          end
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 15; i++) begin
          x_d[i] = x_q[i+1];
        end
        x_d[15] = sum;
        idx_d   = idx_q + 4'd1;
        if (idx_q == 4'hF) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  assign rd_word_o     = x_q[rd_idx_i];
  assign status_o.busy = (state_q != ST_IDLE);
  assign status_o.done = (state_q == ST_ADD) && (idx_q == 4'hF);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ST_IDLE)
    else $error("block start while core busy");

  a_add_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD && idx_q == 4'hF) |=> state_q == ST_IDLE)
    else $error("add-back pass did not finish");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> (idx_q == 4'h0 && round_q == '0))
    else $error("sequencer counters not cleared in idle");

endmodule

FILE: tb/sv/tb_salsa20_stream_cipher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_salsa20_stream_cipher
// Self-checking bench for the Salsa20 byte-stream encryptor. A directed table
// covers reset state, key size and key changes mid-block, nonce restarts,
// message ends and ignored register indexes. Random messages follow under
// random source and sink stalls. Every output beat is checked against a local
// Salsa20 keystream model.
// ----------------------------------------------------------------------------
module tb_salsa20_stream_cipher;
  import s20_pkg::*;

  localparam int unsigned Rounds     = RoundCountDef;
  localparam int unsigned RandItems  = 650;
  localparam int unsigned TailCycles = 16 * Rounds + 18 + 32;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;
  localparam logic [31:0] Tau1   = 32'h3120646e;
  localparam logic [31:0] Tau2   = 32'h79622d36;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [15:0][31:0]  word16_t;

  localparam cfg_idx_t RegSpareLo = 3'd6;
  localparam cfg_idx_t RegSpareHi = 3'd7;

  typedef enum logic {ROW_DATA, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    cfg_idx_t    idx;
    logic [63:0] val;
    logic [7:0]  data;
    logic        last;
  } dir_row_t;

  typedef struct packed {
    logic        is_reg;
    cfg_idx_t    idx;
    logic [63:0] val;
    logic [7:0]  data;
    logic        last;
  } feed_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } cipher_out_t;

  localparam dir_row_t DirRows [24] = '{
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'h00, 1'b0},
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'hff, 1'b0},
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'ha5, 1'b1},
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'h5a, 1'b0},
    '{ROW_REG,  REG_KEY_01,     64'hffff_ffff_ffff_ffff, 8'h00, 1'b0},
    '{ROW_REG,  REG_KEY_67,     64'h0,                   8'h00, 1'b0},
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'h3c, 1'b0},
    '{ROW_REG,  REG_KEY_IS_256, 64'h0,                   8'h00, 1'b0},
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'hc3, 1'b1},
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'h00, 1'b0},
    '{ROW_REG,  REG_NONCE,      64'hffff_ffff_ffff_ffff, 8'h00, 1'b0},
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'hff, 1'b0},
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'h80, 1'b0},
    '{ROW_REG,  REG_KEY_23,     64'h0123_4567_89ab_cdef, 8'h00, 1'b0},
    '{ROW_REG,  REG_KEY_45,     64'hfedc_ba98_7654_3210, 8'h00, 1'b0},
    '{ROW_REG,  RegSpareLo,     64'hffff_ffff_ffff_ffff, 8'h00, 1'b0},
    '{ROW_REG,  RegSpareHi,     64'h0,                   8'h00, 1'b0},
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'h01, 1'b1},
    '{ROW_REG,  REG_KEY_IS_256, 64'hffff_ffff_ffff_fffe, 8'h00, 1'b0},
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'h7f, 1'b1},
    '{ROW_REG,  REG_KEY_IS_256, 64'h0000_0000_0000_0001, 8'h00, 1'b0},
    '{ROW_REG,  REG_NONCE,      64'h0,                   8'h00, 1'b0},
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'hfe, 1'b0},
    '{ROW_DATA, REG_KEY_01,     64'h0,                   8'h10, 1'b1}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_t    cfg_index_i   = '0;
  logic [63:0] cfg_data_i    = '0;

  // keystream model state
  logic [63:0] ks_key01 = '0;
  logic [63:0] ks_key23 = '0;
  logic [63:0] ks_key45 = '0;
  logic [63:0] ks_key67 = '0;
  logic [63:0] ks_nonce = '0;
  logic        ks_wide  = 1'b1;
  word16_t     ks_words = '0;
  logic [5:0]  ks_pos   = '0;
  logic [63:0] ks_ctr   = '0;

  feed_t       feed_q [$];
  cipher_out_t cipher_q [$];

  logic        src_idle_en  = 1'b1;
  logic        sink_idle_en = 1'b1;
  int unsigned src_gap      = 0;
  int unsigned sink_gap     = 0;
  int unsigned quiet        = 0;
  logic        next_src;
  logic        next_cfg;
  feed_t       head;

  int unsigned mismatches  = 0;
  int unsigned bytes_seen  = 0;
  int unsigned msgs_seen   = 0;
  int unsigned blocks_made = 0;
  int unsigned wide_blocks = 0;
  int unsigned regs_done   = 0;

  salsa20_stream_cipher #(
    .ROUND_COUNT(Rounds)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter(inout word16_t x, input int unsigned a, b, c, d);
    x[b] = x[b] ^ rol32(x[a] + x[d], 7);
    x[c] = x[c] ^ rol32(x[b] + x[a], 9);
    x[d] = x[d] ^ rol32(x[c] + x[b], 13);
    x[a] = x[a] ^ rol32(x[d] + x[c], 18);
  endfunction

  function automatic word16_t salsa_block(input logic [63:0] ctr);
    word16_t     seed;
    word16_t     x;
    logic [63:0] upper_a;
    logic [63:0] upper_b;
    upper_a  = ks_wide ? ks_key45 : ks_key01;
    upper_b  = ks_wide ? ks_key67 : ks_key23;
    seed[0]  = Sigma0;
    seed[1]  = ks_key01[31:0];
    seed[2]  = ks_key01[63:32];
    seed[3]  = ks_key23[31:0];
    seed[4]  = ks_key23[63:32];
    seed[5]  = ks_wide ? Sigma1 : Tau1;
    seed[6]  = ks_nonce[31:0];
    seed[7]  = ks_nonce[63:32];
    seed[8]  = ctr[31:0];
    seed[9]  = ctr[63:32];
    seed[10] = ks_wide ? Sigma2 : Tau2;
    seed[11] = upper_a[31:0];
    seed[12] = upper_a[63:32];
    seed[13] = upper_b[31:0];
    seed[14] = upper_b[63:32];
    seed[15] = Sigma3;
    x = seed;
    for (int unsigned r = 0; r < Rounds; r++) begin
      if (r % 2 == 0) begin
        quarter(x, 0, 4, 8, 12);
        quarter(x, 5, 9, 13, 1);
        quarter(x, 10, 14, 2, 6);
        quarter(x, 15, 3, 7, 11);
      end else begin
        quarter(x, 0, 1, 2, 3);
        quarter(x, 5, 6, 7, 4);
        quarter(x, 10, 11, 8, 9);
        quarter(x, 15, 12, 13, 14);
      end
    end
    for (int i = 0; i < 16; i++) x[i] = x[i] + seed[i];
    return x;
  endfunction

  function automatic void encrypt_byte(input logic [7:0] d, input logic l);
    cipher_out_t e;
    logic [31:0] w;
    if (ks_pos == 6'd0) begin
      ks_words = salsa_block(ks_ctr);
      ks_ctr = ks_ctr + 64'd1;
      blocks_made++;
      if (ks_wide) wide_blocks++;
    end
    w = ks_words[ks_pos[5:2]];
    e.out_byte = d ^ w[8*ks_pos[1:0] +: 8];
    e.out_last = l;
    cipher_q.push_back(e);
    ks_pos = l ? 6'd0 : ks_pos + 6'd1;
    bytes_seen++;
    if (l) msgs_seen++;
  endfunction

  function automatic void apply_reg(input cfg_idx_t idx, input logic [63:0] val);
    regs_done++;
    case (idx)
      REG_KEY_01:     ks_key01 = val;
      REG_KEY_23:     ks_key23 = val;
      REG_KEY_45:     ks_key45 = val;
      REG_KEY_67:     ks_key67 = val;
      REG_NONCE: begin
        ks_nonce = val;
        ks_ctr   = '0;
        ks_pos   = '0;
      end
      REG_KEY_IS_256: ks_wide = val[0];
      default: ;
    endcase
  endfunction

  function automatic void check_beat(input logic [7:0] b, input logic l);
    cipher_out_t e;
    if (cipher_q.size() == 0) begin
      $error("out_byte: no beat expected, got %02h", b);
      mismatches++;
    end else begin
      e = cipher_q.pop_front();
      if (b !== e.out_byte) begin
        $error("out_byte: expected %02h, got %02h", e.out_byte, b);
        mismatches++;
      end
      if (l !== e.out_last) begin
        $error("out_last: expected %0b, got %0b", e.out_last, l);
        mismatches++;
      end
    end
  endfunction

  function automatic void push_reg(input cfg_idx_t idx, input logic [63:0] val);
    feed_t f;
    f = '0;
    f.is_reg = 1'b1;
    f.idx    = idx;
    f.val    = val;
    feed_q.push_back(f);
  endfunction

  function automatic void push_byte(input logic [7:0] d, input logic l);
    feed_t f;
    f = '0;
    f.data = d;
    f.last = l;
    feed_q.push_back(f);
  endfunction

  function automatic logic [63:0] rand_word64();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      cfg_valid_i   <= 1'b0;
      cfg_index_i   <= '0;
      cfg_data_i    <= '0;
      m_axis_tready <= 1'b0;
      src_gap  = 0;
      sink_gap = 0;
      quiet    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_beat(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) encrypt_byte(s_axis_tdata, s_axis_tlast);
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (cipher_q.size() == 0 && !s_axis_tvalid) begin
        if (quiet < 16) quiet++;
      end else begin
        quiet = 0;
      end

      if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end

      // hold any beat not yet taken
      if (!(s_axis_tvalid && !s_axis_tready) && !(cfg_valid_i && !cfg_ready_o)) begin
        next_src = 1'b0;
        next_cfg = 1'b0;
        if (feed_q.size() != 0) begin
          if (feed_q[0].is_reg) begin
            if (quiet >= 4) begin
              head = feed_q.pop_front();
              next_cfg = 1'b1;
              cfg_index_i <= head.idx;
              cfg_data_i  <= head.val;
            end
          end else if (src_gap != 0) begin
            src_gap--;
          end else if (src_idle_en && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(0, 7);
          end else begin
            head = feed_q.pop_front();
            next_src = 1'b1;
            s_axis_tdata <= head.data;
            s_axis_tlast <= head.last;
          end
        end
        s_axis_tvalid <= next_src;
        cfg_valid_i   <= next_cfg;
      end
    end
  end

  task automatic wait_drained();
    while (feed_q.size() != 0 || cipher_q.size() != 0 || s_axis_tvalid || cfg_valid_i)
      @(negedge clk_i);
  endtask

  initial begin
    int unsigned rand_items;
    int unsigned goal;
    int unsigned msg_len;
    logic        open_end;
    rand_items = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirRows[i]) begin
      if (DirRows[i].kind == ROW_REG) push_reg(DirRows[i].idx, DirRows[i].val);
      else push_byte(DirRows[i].data, DirRows[i].last);
    end
    wait_drained();

    while (rand_items < RandItems) begin
      src_idle_en  = (rand_items + 100 < RandItems) && ($urandom_range(0, 3) != 0);
      sink_idle_en = (rand_items + 100 < RandItems) && ($urandom_range(0, 3) != 0);
      for (int r = REG_KEY_01; r <= REG_KEY_IS_256; r++)
        if ($urandom_range(0, 2) == 0) push_reg(cfg_idx_t'(r), rand_word64());
      if ($urandom_range(0, 9) == 0)
        push_reg($urandom_range(0, 1) ? RegSpareHi : RegSpareLo, rand_word64());
      goal = rand_items + $urandom_range(30, 70);
      while (rand_items < goal) begin
        msg_len  = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 40);
        open_end = ($urandom_range(0, 7) == 0);
        for (int i = 1; i <= msg_len; i++)
          push_byte(8'($urandom_range(0, 255)), (i == msg_len) && !open_end);
        rand_items += msg_len;
      end
      wait_drained();
    end

    repeat (TailCycles) @(negedge clk_i);
    $display("tb_salsa20_stream_cipher: %0d bytes in %0d messages, %0d register writes",
             bytes_seen, msgs_seen, regs_done);
    $display("tb_salsa20_stream_cipher: %0d keystream blocks, %0d with 256-bit key",
             blocks_made, wide_blocks);
    if (mismatches == 0) begin
      $display("tb_salsa20_stream_cipher: clean");
    end else begin
      $display("tb_salsa20_stream_cipher: errors");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb_salsa20_stream_cipher: errors");
    $finish;
  end

endmodule
